@@ hdl/nearest_vector_store_assert.svh @@
// ------------------------------------------------------------------------
// nearest_vector_store_assert.svh
// assertion macros used by the checker file of the vector store
// ------------------------------------------------------------------------
`ifndef NEAREST_VECTOR_STORE_ASSERT_SVH
`define NEAREST_VECTOR_STORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define NVS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define NVS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/nvs_pkg.sv @@
// ------------------------------------------------------------------------
// nvs_pkg
// shared types, codes and default sizes of the nearest vector store
// ------------------------------------------------------------------------
package nvs_pkg;

    // default sizes
    localparam int MAX_VECTORS_DEF  = 1024;
    localparam int DIM_MAX_DEF      = 64;
    localparam int ELEMENT_BITS_DEF = 16;

    // dimension register
    localparam int         DIM_W     = 7;
    localparam logic [6:0] DIM_RESET = 7'd64;

    // result word layout
    localparam int STATUS_W   = 2;
    localparam int OUT_ID_W   = 10;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - OUT_ID_W;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // command carried on the last element
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } command_t;

    // tag that travels with each memory read of a scan
    typedef struct packed {
        logic valid;
        logic row_zero;
        logic row_first;
        logic row_last;
        logic scan_last;
    } nvs_tap_t;

endpackage

@@ hdl/nvs_ram.sv @@
// ------------------------------------------------------------------------
// nvs_ram
// simple dual-port synchronous ram, one write and one registered read
// ------------------------------------------------------------------------
module nvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/nvs_dist.sv @@
// ------------------------------------------------------------------------
// nvs_dist
// squared distance pipeline: difference, square, accumulate, best row
// ------------------------------------------------------------------------
module nvs_dist
    import nvs_pkg::*;
#(
    parameter int ELEM_W = ELEMENT_BITS_DEF,
    parameter int ID_W   = 10,
    parameter int ACC_W  = 40
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nvs_tap_t          tap,
    input  logic [ELEM_W-1:0] query_elem,
    input  logic [ELEM_W-1:0] row_elem,
    output logic              done,
    output logic [ID_W-1:0]   best_id
);

    logic signed [ELEM_W:0] diff;
    logic signed [ELEM_W:0] diff_abs;
    logic [ELEM_W-1:0]      mag_reg;
    logic [2*ELEM_W-1:0]    sq;
    logic [2*ELEM_W-1:0]    sq_reg;
    logic [ACC_W:0]         acc_sum;
    logic [ACC_W-1:0]       acc_next;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       best_dist_reg;
    logic [ID_W-1:0]        best_id_reg;
    logic [ID_W-1:0]        row_cnt_reg;
    logic [ID_W-1:0]        cur_id;
    logic                   done_reg;
    nvs_tap_t               tap_a_reg;
    nvs_tap_t               tap_b_reg;
    nvs_tap_t               tap_c_reg;

    // element difference and magnitude
    assign diff     = $signed({query_elem[ELEM_W-1], query_elem})
                    - $signed({row_elem[ELEM_W-1], row_elem});
    assign diff_abs = diff[ELEM_W] ? -diff : diff;

    // square of the magnitude
    assign sq = (2*ELEM_W)'(mag_reg) * (2*ELEM_W)'(mag_reg);

    // saturating accumulate, restarted at the first element of a row
    assign acc_sum = {1'b0, acc_reg} + (ACC_W+1)'(sq_reg);
    always_comb
    begin
        if (tap_b_reg.row_first)
        begin
            acc_next = ACC_W'(sq_reg);
        end
        else if (acc_sum[ACC_W])
        begin
            acc_next = '1;
        end
        else
        begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    // id of the row that ends at the compare stage
    assign cur_id = tap_c_reg.row_zero ? '0 : row_cnt_reg;

    // tag pipeline and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_a_reg   <= '0;
            tap_b_reg   <= '0;
            tap_c_reg   <= '0;
            done_reg    <= 1'b0;
            row_cnt_reg <= '0;
        end
        else
        begin
            tap_a_reg <= tap;
            tap_b_reg <= tap_a_reg;
            tap_c_reg <= tap_b_reg;
            done_reg  <= tap_c_reg.valid & tap_c_reg.scan_last;
            if (tap_c_reg.valid && tap_c_reg.row_last)
            begin
                row_cnt_reg <= cur_id + ID_W'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg <= diff_abs[ELEM_W-1:0];
        sq_reg  <= sq;
        if (tap_b_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        // strict less keeps the lowest id among equal distances
        if (tap_c_reg.valid && tap_c_reg.row_last
            && (tap_c_reg.row_zero || (acc_reg < best_dist_reg)))
        begin
            best_dist_reg <= acc_reg;
            best_id_reg   <= cur_id;
        end
    end

    assign done    = done_reg;
    assign best_id = best_id_reg;

endmodule

@@ hdl/nearest_vector_store.sv @@
// ------------------------------------------------------------------------
// nearest_vector_store
// bounded vector store with brute-force nearest search by squared L2
// ------------------------------------------------------------------------
// Elements stream in on s_axis, one per transfer: tdata is the signed
// element, tlast marks the final element, tuser is the command (insert or
// search) and counts only on the final element. Each final element gives
// one result transfer on m_axis with a status code and a vector id.
// Elements are taken one per cycle while the block waits in its receive
// state. An insert whose length is DIM_MAX answers at once; a shorter
// insert first clears the rest of its row. A search reads every stored
// element once through the single read port of the vector memory, then
// a four-stage distance pipeline drains.
// Errors (empty store, dimension mismatch, store full) answer at once.
// The result waits in an output register while m_axis_tready is low;
// further elements are still taken meanwhile, and the result state
// stalls only when a new result is due while the old one is still held.
// Reset empties the store and sets the dimension to 64; memory contents
// are left as they are and need no clearing pass.
// ------------------------------------------------------------------------
module nearest_vector_store
    import nvs_pkg::*;
#(
    parameter int MAX_VECTORS  = MAX_VECTORS_DEF,
    parameter int DIM_MAX      = DIM_MAX_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [DIM_W-1:0]                    cfg_wr_data,    // dimension
    // element stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((ELEMENT_BITS+7)/8)*8-1:0]   s_axis_tdata,   // element_value
    input  logic                                s_axis_tlast,   // last_element
    input  logic                                s_axis_tuser,   // command
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [OUT_DATA_W-1:0]               m_axis_tdata    // status, vector_id, pad
);

    localparam int ID_W   = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int CW     = $clog2(MAX_VECTORS + 1);
    localparam int POS_W  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int PW     = $clog2(DIM_MAX + 2);
    localparam int VDEPTH = MAX_VECTORS * DIM_MAX;
    localparam int AW     = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
    localparam int CMPW   = (PW > DIM_W) ? PW : DIM_W;
    localparam int NAT_W  = 2 * ELEMENT_BITS + $clog2(DIM_MAX);
    localparam int ACC_W  = (NAT_W > 64) ? 64 : NAT_W;

    typedef enum logic [4:0] {
        S_RECV   = 5'b00001,
        S_FILL   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           count_base_reg, count_base_next;
    logic [DIM_W-1:0]        dimension_reg;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [AW-1:0]           row_base_reg, row_base_next;
    logic [POS_W-1:0]        d_reg, d_next;
    logic [ID_W-1:0]         row_reg, row_next;
    logic [POS_W-1:0]        lenm1_reg, lenm1_next;
    logic                    out_valid_reg, out_valid_next;
    nvs_tap_t                tap_next, tap_rd_reg;
    status_t                 res_status_reg, res_status_next;
    logic [ID_W-1:0]         res_id_reg, res_id_next;
    status_t                 out_status_reg;
    logic [OUT_ID_W-1:0]     out_id_reg;
    logic                    load_out;

    logic                    accept;
    logic [ELEMENT_BITS-1:0] elem;
    logic [POS_W-1:0]        pos_idx;
    logic                    in_room;
    logic [PW-1:0]           len;
    logic                    len_ok;
    logic                    count_full;
    logic                    row_last;
    logic                    scan_last;

    logic                    vm_we;
    logic [AW-1:0]           vm_waddr;
    logic [ELEMENT_BITS-1:0] vm_wdata;
    logic [ELEMENT_BITS-1:0] vm_rdata;
    logic [ELEMENT_BITS-1:0] qb_rdata;
    logic                    dist_done;
    logic [ID_W-1:0]         best_id;

    // input transfer and element bookkeeping
    assign s_axis_tready = (state_reg == S_RECV);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign elem          = s_axis_tdata[ELEMENT_BITS-1:0];
    assign pos_idx       = pos_reg[POS_W-1:0];
    assign in_room       = (pos_reg < PW'(DIM_MAX));
    assign len           = (pos_reg <= PW'(DIM_MAX)) ? pos_reg + PW'(1) : pos_reg;
    assign len_ok        = (CMPW'(len) == CMPW'(dimension_reg)) && (len <= PW'(DIM_MAX));
    assign count_full    = (count_reg >= CW'(MAX_VECTORS));

    // scan position flags
    assign row_last  = (d_reg == lenm1_reg);
    assign scan_last = row_last && ((CW'(row_reg) + CW'(1)) == count_reg);

    // vector memory write: staging at the free row, zero fill of a short row
    always_comb
    begin
        if (state_reg == S_FILL)
        begin
            vm_we    = 1'b1;
            vm_waddr = addr_reg;
            vm_wdata = '0;
        end
        else
        begin
            vm_we    = accept & in_room & ~count_full;
            vm_waddr = count_base_reg + AW'(pos_idx);
            vm_wdata = elem;
        end
    end

    nvs_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (VDEPTH)
    ) u_vector_mem (
        .clk     (clk),
        .wr_en   (vm_we),
        .wr_addr (vm_waddr),
        .wr_data (vm_wdata),
        .rd_addr (addr_reg),
        .rd_data (vm_rdata)
    );

    nvs_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (DIM_MAX)
    ) u_query_buf (
        .clk     (clk),
        .wr_en   (accept & in_room),
        .wr_addr (pos_idx),
        .wr_data (elem),
        .rd_addr (d_reg),
        .rd_data (qb_rdata)
    );

    nvs_dist #(
        .ELEM_W (ELEMENT_BITS),
        .ID_W   (ID_W),
        .ACC_W  (ACC_W)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .tap        (tap_rd_reg),
        .query_elem (qb_rdata),
        .row_elem   (vm_rdata),
        .done       (dist_done),
        .best_id    (best_id)
    );

    // control sequencer
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        count_base_next = count_base_reg;
        addr_next       = addr_reg;
        row_base_next   = row_base_reg;
        d_next          = d_reg;
        row_next        = row_reg;
        lenm1_next      = lenm1_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        out_valid_next  = out_valid_reg;
        tap_next        = '0;
        load_out        = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_RECV:
            begin
                if (accept)
                begin
                    if (s_axis_tlast)
                    begin
                        pos_next    = '0;
                        res_id_next = '0;
                        state_next  = S_RESULT;
                        if (command_t'(s_axis_tuser) == CMD_INSERT)
                        begin
                            if (!len_ok)
                            begin
                                res_status_next = ST_MISMATCH;
                            end
                            else if (count_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                // commit the staged row
                                res_status_next = ST_OK;
                                res_id_next     = ID_W'(count_reg);
                                count_next      = count_reg + CW'(1);
                                count_base_next = count_base_reg + AW'(DIM_MAX);
                                if (len != PW'(DIM_MAX))
                                begin
                                    addr_next  = count_base_reg + AW'(len);
                                    d_next     = POS_W'(len);
                                    state_next = S_FILL;
                                end
                            end
                        end
                        else
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (!len_ok)
                            begin
                                res_status_next = ST_MISMATCH;
                            end
                            else
                            begin
                                lenm1_next    = POS_W'(len - PW'(1));
                                addr_next     = '0;
                                row_base_next = '0;
                                d_next        = '0;
                                row_next      = '0;
                                state_next    = S_SCAN;
                            end
                        end
                    end
                    else if (pos_reg <= PW'(DIM_MAX))
                    begin
                        pos_next = pos_reg + PW'(1);
                    end
                end
            end

            S_FILL:
            begin
                addr_next = addr_reg + AW'(1);
                d_next    = d_reg + POS_W'(1);
                if (d_reg == POS_W'(DIM_MAX - 1))
                begin
                    state_next = S_RESULT;
                end
            end

            S_SCAN:
            begin
                tap_next.valid     = 1'b1;
                tap_next.row_zero  = (row_reg == '0);
                tap_next.row_first = (d_reg == '0);
                tap_next.row_last  = row_last;
                tap_next.scan_last = scan_last;
                if (row_last)
                begin
                    d_next        = '0;
                    row_next      = row_reg + ID_W'(1);
                    row_base_next = row_base_reg + AW'(DIM_MAX);
                    addr_next     = row_base_reg + AW'(DIM_MAX);
                end
                else
                begin
                    d_next    = d_reg + POS_W'(1);
                    addr_next = addr_reg + AW'(1);
                end
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                if (dist_done)
                begin
                    res_status_next = ST_OK;
                    res_id_next     = best_id;
                    state_next      = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_RECV;
                end
            end

            default:
            begin
                state_next = S_RECV;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RECV;
            pos_reg        <= '0;
            count_reg      <= '0;
            count_base_reg <= '0;
            dimension_reg  <= DIM_RESET;
            addr_reg       <= '0;
            row_base_reg   <= '0;
            d_reg          <= '0;
            row_reg        <= '0;
            out_valid_reg  <= 1'b0;
            tap_rd_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            count_base_reg <= count_base_next;
            addr_reg       <= addr_next;
            row_base_reg   <= row_base_next;
            d_reg          <= d_next;
            row_reg        <= row_next;
            out_valid_reg  <= out_valid_next;
            tap_rd_reg     <= tap_next;
            if (cfg_wr_en)
            begin
                dimension_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lenm1_reg      <= lenm1_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= OUT_ID_W'(res_id_reg);
        end
    end

    // result transfer
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_id_reg, out_status_reg};

endmodule

@@ hdl/nvs_check.sv @@
// ------------------------------------------------------------------------
// nvs_check
// port-level checks on the nearest vector store, bound to the top level
// ------------------------------------------------------------------------
`include "nearest_vector_store_assert.svh"

module nvs_check
    import nvs_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [1:0] pending_reg;
    logic       in_last;
    logic       out_xfer;

    assign in_last  = s_axis_tvalid & s_axis_tready & s_axis_tlast;
    assign out_xfer = m_axis_tvalid & m_axis_tready;

    // final elements taken whose result has not yet been transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else if (in_last && !out_xfer)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (!in_last && out_xfer)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    // a held result keeps its value
    `NVS_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // every result has a final element behind it
    `NVS_ASSERT_NOW(a_out_has_cause, clk, rst_n, m_axis_tvalid,
        pending_reg != 2'd0, "result without a final element")

    // a new final element is taken only while at most one earlier result is untransferred
    `NVS_ASSERT_NOW(a_one_in_work, clk, rst_n, in_last,
        pending_reg <= 2'd1, "final element taken while one is in work")

    // an error result carries id zero
    `NVS_ASSERT_NOW(a_error_id_zero, clk, rst_n,
        m_axis_tvalid && (m_axis_tdata[STATUS_W-1:0] != ST_OK),
        m_axis_tdata[STATUS_W+OUT_ID_W-1:STATUS_W] == '0, "error result with nonzero id")

endmodule

bind nearest_vector_store nvs_check u_nvs_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
